/* design/linear_predict_nibble_encoder_top_defines.svh */
// Assertion macros shared by the linear prediction nibble encoder.
`ifndef LINEAR_PREDICT_NIBBLE_ENCODER_TOP_DEFINES_SVH
`define LINEAR_PREDICT_NIBBLE_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LPNE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LPNE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/lpne_pkg.sv */
// Types and constants of the linear prediction nibble encoder.
`timescale 1ns / 1ps

package lpne_pkg;

  localparam int unsigned SampleW   = 32;
  localparam int unsigned NibW      = 4;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned NibsPerS  = SampleW / NibW;   // 8
  localparam int unsigned MaxBytes  = 5;
  localparam int unsigned RawBytes  = SampleW / ByteW;  // 4
  localparam int unsigned NibListN  = NibsPerS + 2;     // carry + header + nibbles

  localparam logic [NibW-1:0] NibZero = 4'h0;
  localparam logic [NibW-1:0] NibOnes = 4'hf;
  localparam logic [3:0]      OnesHeadBase = 4'h8;

  // Samples taken so far in the current stream
  localparam logic [1:0] SeenNone = 2'd0;
  localparam logic [1:0] SeenOne  = 2'd1;
  localparam logic [1:0] SeenTwo  = 2'd2;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               is_last;
  } in_word_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             run_end;
    logic             stream_end;
  } out_word_t;

  // Encoder history carried from one sample to the next
  typedef struct packed {
    logic [SampleW-1:0] older;
    logic [SampleW-1:0] newer;
    logic [1:0]         seen;
    logic [NibW-1:0]    carry_nib;
    logic               carry_vld;
  } hist_t;

  // All bytes caused by one sample
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [2:0]                     count;
    logic                           stream_last;
  } bundle_t;

endpackage

/* design/lpne_code.sv */
// Residual coder: prediction, header nibble and nibble-to-byte packing for one sample.
`timescale 1ns / 1ps

module lpne_code (
  input  lpne_pkg::in_word_t item_i,
  input  lpne_pkg::hist_t    hist_i,
  output lpne_pkg::bundle_t  bundle_o,
  output lpne_pkg::hist_t    hist_o
);

  logic [lpne_pkg::SampleW-1:0] pred;
  logic [lpne_pkg::SampleW-1:0] resid;
  logic [lpne_pkg::NibW-1:0]    top;
  logic [3:0]                   lead;
  logic                         run;
  logic [3:0]                   head;
  logic [lpne_pkg::NibListN-1:0][lpne_pkg::NibW-1:0] list;
  logic [3:0]                   cnt;
  logic [3:0]                   tail_idx;
  logic [2:0]                   half;
  logic                         flush;

  // Predict and take the residual modulo 2^32
  assign pred  = hist_i.newer + (hist_i.newer - hist_i.older);
  assign resid = item_i.sample - pred;
  assign top   = resid[lpne_pkg::SampleW-1 -: lpne_pkg::NibW];

  // Count leading zero or leading ones nibbles and form the header
  always_comb begin
    lead = 4'd0;
    run  = 1'b1;
    if (top == lpne_pkg::NibZero) begin
      for (int k = 0; k < 8; k++) begin
        if (run && resid[31-4*k -: 4] == lpne_pkg::NibZero) begin
          lead = lead + 4'd1;
        end else begin
          run = 1'b0;
        end
      end
    end else if (top == lpne_pkg::NibOnes) begin
      for (int k = 0; k < 7; k++) begin
        if (run && resid[31-4*k -: 4] == lpne_pkg::NibOnes) begin
          lead = lead + 4'd1;
        end else begin
          run = 1'b0;
        end
      end
    end
    head = (top == lpne_pkg::NibOnes) ? (lead + lpne_pkg::OnesHeadBase) : lead;
  end

  // Line up nibbles in stream order: carry, header, residual low nibble first
  always_comb begin
    list = '0;
    if (hist_i.carry_vld) begin
      list[0] = hist_i.carry_nib;
      list[1] = head;
      for (int k = 0; k < 8; k++) begin
        list[2+k] = resid[4*k +: 4];
      end
    end else begin
      list[0] = head;
      for (int k = 0; k < 8; k++) begin
        list[1+k] = resid[4*k +: 4];
      end
    end
  end

  assign cnt      = 4'd9 - lead + {3'b000, hist_i.carry_vld};
  assign tail_idx = cnt - 4'd1;
  assign half     = cnt[3:1];
  assign flush    = cnt[0] & item_i.is_last;

  // Pack bytes and advance the history
  always_comb begin
    bundle_o             = '0;
    bundle_o.stream_last = item_i.is_last;
    hist_o               = hist_i;
    if (hist_i.seen != lpne_pkg::SeenTwo) begin
      // Raw sample, little-endian
      for (int j = 0; j < lpne_pkg::RawBytes; j++) begin
        bundle_o.bytes[j] = item_i.sample[8*j +: 8];
      end
      bundle_o.count = 3'(lpne_pkg::RawBytes);
      if (hist_i.seen == lpne_pkg::SeenNone) begin
        hist_o.older = item_i.sample;
      end else begin
        hist_o.newer = item_i.sample;
      end
      hist_o.seen = hist_i.seen + 2'd1;
    end else begin
      for (int j = 0; j < lpne_pkg::MaxBytes; j++) begin
        bundle_o.bytes[j] = {list[2*j], list[2*j+1]};
      end
      if (flush) begin
        bundle_o.bytes[half] = {list[tail_idx], lpne_pkg::NibZero};
      end
      bundle_o.count   = half + {2'b00, flush};
      hist_o.carry_vld = cnt[0] & ~item_i.is_last;
      hist_o.carry_nib = (cnt[0] & ~item_i.is_last) ? list[tail_idx] : lpne_pkg::NibZero;
      hist_o.older     = hist_i.newer;
      hist_o.newer     = item_i.sample;
    end
    // Start a fresh stream after the final sample
    if (item_i.is_last) begin
      hist_o = '0;
    end
  end

endmodule

/* design/lpne_emit.sv */
// Result register and byte serializer: holds one sample's bytes and hands them out one per word.
`timescale 1ns / 1ps

module lpne_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  lpne_pkg::bundle_t   bundle_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpne_pkg::out_word_t out_word_o
);

  lpne_pkg::bundle_t bnd_q, bnd_d;
  logic              vld_q, vld_d;
  logic [2:0]        idx_q, idx_d;
  logic              take;
  logic              at_end;

  assign take   = vld_q & ~out_stall_i;
  assign at_end = (idx_q == (bnd_q.count - 3'd1));
  assign free_o = ~vld_q | (take & at_end);

  // Drive the current byte
  assign out_valid_o           = vld_q;
  assign out_word_o.out_byte   = bnd_q.bytes[idx_q];
  assign out_word_o.run_end    = at_end;
  assign out_word_o.stream_end = at_end & bnd_q.stream_last;

  // Load a new bundle, or advance through the held one
  always_comb begin
    bnd_d = bnd_q;
    vld_d = vld_q;
    idx_d = idx_q;
    if (load_i) begin
      bnd_d = bundle_i;
      vld_d = (bundle_i.count != 3'd0);
      idx_d = 3'd0;
    end else if (take) begin
      if (at_end) begin
        vld_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 3'd0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bnd_q <= bnd_d;
  end

endmodule

/* design/linear_predict_nibble_encoder_top.sv */
// Top level of the linear prediction nibble encoder: input register, history and serializer.
//
//  channel  | handshake                 | word
//  ---------+---------------------------+-------------------------------------------
//  in       | in_valid_i / in_stall_o   | in_word_i  : sample (32), is_last (1)
//  out      | out_valid_o / out_stall_i | out_word_o : out_byte (8), run_end, stream_end
//
// A sample waits in the input register and is coded in the cycle it moves into the result
// register; that sample's bytes then leave at one per cycle while out_stall_i is low.
// The byte serializer sets the throughput: the result register takes the next sample in the
// cycle its last byte is taken. A sample that makes no byte only updates the history.
// Reset clears the history, so the next word starts a new stream.
// A stalled output holds the current byte; the input register then fills and stalls.
`timescale 1ns / 1ps
`include "linear_predict_nibble_encoder_top_defines.svh"

module linear_predict_nibble_encoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lpne_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpne_pkg::out_word_t out_word_o
);

  lpne_pkg::in_word_t in_q;
  logic               in_vld_q, in_vld_d;
  lpne_pkg::hist_t    hist_q, hist_d;
  lpne_pkg::bundle_t  bundle;
  logic               free;
  logic               move;
  logic               accept;

  // Move the held sample into the result register when it is free
  assign move       = in_vld_q & free;
  assign in_stall_o = in_vld_q & ~free;
  assign accept     = in_valid_i & ~in_stall_o;
  assign in_vld_d   = accept | (in_vld_q & ~move);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      hist_q   <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      if (move) begin
        hist_q <= hist_d;
      end
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_word_i;
    end
  end

  lpne_code u_code (
    .item_i   (in_q),
    .hist_i   (hist_q),
    .bundle_o (bundle),
    .hist_o   (hist_d)
  );

  lpne_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (move),
    .bundle_i    (bundle),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // Checks
  `LPNE_ASSERT_NEXT(a_fresh_after_last, move && in_q.is_last, hist_q == '0,
                    "history not cleared after final sample")
  `LPNE_ASSERT_IMP(a_carry_needs_hist, hist_q.carry_vld, hist_q.seen == lpne_pkg::SeenTwo,
                   "carry nibble before prediction starts")
  `LPNE_ASSERT_NEXT(a_raw_bytes_out, move && (hist_q.seen != lpne_pkg::SeenTwo), out_valid_o,
                    "raw sample made no bytes")

endmodule
